FILE: hdl/sld_pkg.sv
// ----------------------------------------------------------------------------
// sld_pkg
// Shared types, register codes and the CRC-16/CCITT byte update for the
// sync/length/CRC16 deframer.
// ----------------------------------------------------------------------------
package sld_pkg;

   typedef enum logic [3:0] {
      PH_SYNC1   = 4'd0,
      PH_SYNC2   = 4'd1,
      PH_ADDR    = 4'd2,
      PH_CMD     = 4'd3,
      PH_LENH    = 4'd4,
      PH_LENL    = 4'd5,
      PH_PAYLOAD = 4'd6,
      PH_CRCH    = 4'd7,
      PH_CRCL    = 4'd8
   } phase_type;

   typedef enum logic [1:0] {
      KIND_PAYLOAD = 2'd0,
      KIND_ACCEPT  = 2'd1,
      KIND_REJECT  = 2'd2
   } kind_type;

   localparam int CSR_ADDR_BITS = 4;
   localparam int CSR_DATA_BITS = 32;

   typedef enum logic [1:0] {
      REG_SYNC_FIRST  = 2'd0,
      REG_SYNC_SECOND = 2'd1,
      REG_MAX_LEN     = 2'd2
   } reg_index_type;

   localparam logic [7:0]  SYNC_FIRST_RESET  = 8'hAA;
   localparam logic [7:0]  SYNC_SECOND_RESET = 8'h55;
   localparam logic [15:0] MAX_LEN_RESET     = 16'd1024;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'h1021;

   typedef struct packed {
      logic [7:0]  sync_first;
      logic [7:0]  sync_second;
      logic [15:0] max_payload_len;
   } cfg_type;

   // MSB-first CRC update over one byte
   function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] c;
      c = crc ^ {data, 8'h00};
      for (int i = 0; i < 8; i++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

FILE: hdl/sld_stream_if.sv
// ----------------------------------------------------------------------------
// sld_stream_if
// Valid/ready channels of the deframer: received bytes in, results out.
// ----------------------------------------------------------------------------
interface sld_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
   modport mon    (input valid, input rx_byte, input ready);
endinterface

interface sld_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  result_kind;
   logic [7:0]  dest_addr;
   logic [7:0]  command;
   logic [15:0] frame_length;
   logic [15:0] byte_index;
   logic [7:0]  data_byte;
   logic [31:0] fail_count;

   modport source (output valid, output result_kind, output dest_addr, output command,
                   output frame_length, output byte_index, output data_byte,
                   output fail_count, input ready);
   modport sink   (input valid, input result_kind, input dest_addr, input command,
                   input frame_length, input byte_index, input data_byte,
                   input fail_count, output ready);
   modport mon    (input valid, input result_kind, input dest_addr, input command,
                   input frame_length, input byte_index, input data_byte,
                   input fail_count, input ready);
endinterface

FILE: hdl/sld_csr.sv
// ----------------------------------------------------------------------------
// sld_csr
// APB-style register file: sync bytes and payload length limit.
// ----------------------------------------------------------------------------
module sld_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [sld_pkg::CSR_ADDR_BITS-1:0]   paddr,
   input  logic [sld_pkg::CSR_DATA_BITS-1:0]   pwdata,
   output logic [sld_pkg::CSR_DATA_BITS-1:0]   prdata,
   output logic                                pready,
   output sld_pkg::cfg_type                    cfg
);

   sld_pkg::cfg_type cfg_ff;
   sld_pkg::cfg_type cfg_in;
   logic             wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite && pready;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (paddr[3:2])
            sld_pkg::REG_SYNC_FIRST:  cfg_in.sync_first      = pwdata[7:0];
            sld_pkg::REG_SYNC_SECOND: cfg_in.sync_second     = pwdata[7:0];
            sld_pkg::REG_MAX_LEN:     cfg_in.max_payload_len = pwdata[15:0];
            default:                  cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[3:2])
         sld_pkg::REG_SYNC_FIRST:  prdata = sld_pkg::CSR_DATA_BITS'(cfg_ff.sync_first);
         sld_pkg::REG_SYNC_SECOND: prdata = sld_pkg::CSR_DATA_BITS'(cfg_ff.sync_second);
         sld_pkg::REG_MAX_LEN:     prdata = sld_pkg::CSR_DATA_BITS'(cfg_ff.max_payload_len);
         default:                  prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sync_first      <= sld_pkg::SYNC_FIRST_RESET;
         cfg_ff.sync_second     <= sld_pkg::SYNC_SECOND_RESET;
         cfg_ff.max_payload_len <= sld_pkg::MAX_LEN_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

FILE: hdl/sync_length_crc16_deframer.sv
// ----------------------------------------------------------------------------
// sync_length_crc16_deframer
// Hunts for a sync pair, parses address/command/length, streams payload
// bytes out tentatively and gives each in-limit frame a CRC-16 verdict.
// ----------------------------------------------------------------------------
// Pipeline: an accepted byte moves through the input register, then the
//   result register; the CRC byte update and the phase step sit between.
// Throughput: one byte per cycle while the result channel is not stalled
//   (a held result word blocks the input register).
// Reset: synchronous; returns to sync hunting, clears the failure tally and
//   restores the register defaults.
module sync_length_crc16_deframer #(
   parameter int LENGTH_BITS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   sld_req_if.sink                            req,
   sld_rsp_if.source                          rsp,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [sld_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  logic [sld_pkg::CSR_DATA_BITS-1:0]  csr_pwdata,
   output logic [sld_pkg::CSR_DATA_BITS-1:0]  csr_prdata,
   output logic                               csr_pready
);

   localparam logic [16:0] LEN_CAP = 17'((17'd1 << LENGTH_BITS) - 17'd1);

   sld_pkg::cfg_type cfg;

   sld_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   // input stage
   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       advance;

   // parse state
   sld_pkg::phase_type     phase_ff, phase_in;
   logic [7:0]             addr_ff, addr_in;
   logic [7:0]             cmd_ff, cmd_in;
   logic [15:0]            length_ff, length_in;
   logic [LENGTH_BITS-1:0] count_ff, count_in;
   logic [15:0]            crc_ff, crc_in;
   logic [7:0]             check_high_ff, check_high_in;
   logic [31:0]            tally_ff, tally_in;

   // result register
   logic                   out_valid_ff, out_valid_in;
   logic                   out_load;
   sld_pkg::kind_type      out_kind_ff, out_kind_in;
   logic [7:0]             out_addr_ff;
   logic [7:0]             out_cmd_ff;
   logic [15:0]            out_length_ff;
   logic [15:0]            out_index_ff, out_index_in;
   logic [7:0]             out_data_ff, out_data_in;
   logic [31:0]            out_fail_ff;

   logic [7:0]             rx;
   logic [15:0]            length_full;
   logic                   too_long;
   logic                   last_byte;
   logic [15:0]            crc_next;

   assign advance   = in_valid_ff && (!out_valid_ff || rsp.ready);
   assign req.ready = !in_valid_ff || advance;

   assign rx          = in_byte_ff;
   assign length_full = {length_ff[15:8], rx};
   assign too_long    = (length_full > cfg.max_payload_len) || ({1'b0, length_full} > LEN_CAP);
   assign last_byte   = (17'(count_ff) + 17'd1) >= {1'b0, length_ff};
   assign crc_next    = sld_pkg::crc16_byte((phase_ff == sld_pkg::PH_ADDR) ?
                                            sld_pkg::CRC_INIT : crc_ff, rx);

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (advance) begin
         unique case (phase_ff)
            sld_pkg::PH_SYNC2: begin
               if (rx == cfg.sync_second) begin
                  phase_in = sld_pkg::PH_ADDR;
               end else if (rx == cfg.sync_first) begin
                  phase_in = sld_pkg::PH_SYNC2;
               end else begin
                  phase_in = sld_pkg::PH_SYNC1;
               end
            end
            sld_pkg::PH_ADDR: phase_in = sld_pkg::PH_CMD;
            sld_pkg::PH_CMD:  phase_in = sld_pkg::PH_LENH;
            sld_pkg::PH_LENH: phase_in = sld_pkg::PH_LENL;
            sld_pkg::PH_LENL: begin
               if (too_long) begin
                  phase_in = sld_pkg::PH_SYNC1;
               end else if (length_full == 16'd0) begin
                  phase_in = sld_pkg::PH_CRCH;
               end else begin
                  phase_in = sld_pkg::PH_PAYLOAD;
               end
            end
            sld_pkg::PH_PAYLOAD: begin
               if (last_byte) begin
                  phase_in = sld_pkg::PH_CRCH;
               end
            end
            sld_pkg::PH_CRCH: phase_in = sld_pkg::PH_CRCL;
            sld_pkg::PH_CRCL: phase_in = sld_pkg::PH_SYNC1;
            default: begin
               // hunting, and any unused code
               if (rx == cfg.sync_first) begin
                  phase_in = sld_pkg::PH_SYNC2;
               end else begin
                  phase_in = sld_pkg::PH_SYNC1;
               end
            end
         endcase
      end
   end

   // datapath and result
   always_comb begin
      addr_in       = addr_ff;
      cmd_in        = cmd_ff;
      length_in     = length_ff;
      count_in      = count_ff;
      crc_in        = crc_ff;
      check_high_in = check_high_ff;
      tally_in      = tally_ff;
      out_load      = 1'b0;
      out_kind_in   = sld_pkg::KIND_PAYLOAD;
      out_index_in  = length_ff;
      out_data_in   = 8'd0;
      if (advance) begin
         unique case (phase_ff)
            sld_pkg::PH_ADDR: begin
               addr_in = rx;
               crc_in  = crc_next;
            end
            sld_pkg::PH_CMD: begin
               cmd_in = rx;
               crc_in = crc_next;
            end
            sld_pkg::PH_LENH: begin
               length_in = {rx, 8'h00};
               crc_in    = crc_next;
            end
            sld_pkg::PH_LENL: begin
               length_in = length_full;
               crc_in    = crc_next;
               count_in  = '0;
            end
            sld_pkg::PH_PAYLOAD: begin
               crc_in       = crc_next;
               count_in     = count_ff + 1'b1;
               out_load     = 1'b1;
               out_kind_in  = sld_pkg::KIND_PAYLOAD;
               out_index_in = 16'(count_ff);
               out_data_in  = rx;
            end
            sld_pkg::PH_CRCH: begin
               check_high_in = rx;
            end
            sld_pkg::PH_CRCL: begin
               out_load    = 1'b1;
               out_kind_in = sld_pkg::KIND_ACCEPT;
               if ({check_high_ff, rx} != crc_ff) begin
                  tally_in    = tally_ff + 32'd1;
                  out_kind_in = sld_pkg::KIND_REJECT;
               end
            end
            default: begin
               out_load = 1'b0;
            end
         endcase
      end
   end

   always_comb begin
      if (out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         phase_ff      <= sld_pkg::PH_SYNC1;
         addr_ff       <= '0;
         cmd_ff        <= '0;
         length_ff     <= '0;
         count_ff      <= '0;
         crc_ff        <= '0;
         check_high_ff <= '0;
         tally_ff      <= '0;
      end else begin
         if (req.ready) begin
            in_valid_ff <= req.valid;
         end
         out_valid_ff  <= out_valid_in;
         phase_ff      <= phase_in;
         addr_ff       <= addr_in;
         cmd_ff        <= cmd_in;
         length_ff     <= length_in;
         count_ff      <= count_in;
         crc_ff        <= crc_in;
         check_high_ff <= check_high_in;
         tally_ff      <= tally_in;
      end
   end

   // payload registers: load only, no reset
   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         in_byte_ff <= req.rx_byte;
      end
      if (out_load) begin
         out_kind_ff   <= out_kind_in;
         out_addr_ff   <= addr_ff;
         out_cmd_ff    <= cmd_ff;
         out_length_ff <= length_ff;
         out_index_ff  <= out_index_in;
         out_data_ff   <= out_data_in;
         out_fail_ff   <= tally_in;
      end
   end

   assign rsp.valid        = out_valid_ff;
   assign rsp.result_kind  = out_kind_ff;
   assign rsp.dest_addr    = out_addr_ff;
   assign rsp.command      = out_cmd_ff;
   assign rsp.frame_length = out_length_ff;
   assign rsp.byte_index   = out_index_ff;
   assign rsp.data_byte    = out_data_ff;
   assign rsp.fail_count   = out_fail_ff;

endmodule

FILE: hdl/sld_checker.sv
// ----------------------------------------------------------------------------
// sld_checker
// Port-level checks on the deframer result channel, bound to the top level.
// ----------------------------------------------------------------------------
module sld_checker (
   input logic       clock,
   input logic       reset,
   sld_rsp_if.source rsp
);

   // hold a stalled result word
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.result_kind)
         && $stable(rsp.byte_index) && $stable(rsp.data_byte) && $stable(rsp.fail_count))
      else $error("result word changed while stalled");

   // payload words sit inside the announced length
   a_payload_index: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.result_kind == sld_pkg::KIND_PAYLOAD
         |-> rsp.byte_index < rsp.frame_length)
      else $error("payload index beyond frame length");

   // frame-end words carry the length as index and no data
   a_frame_end: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.result_kind != sld_pkg::KIND_PAYLOAD
         |-> (rsp.result_kind == sld_pkg::KIND_ACCEPT || rsp.result_kind == sld_pkg::KIND_REJECT)
             && rsp.byte_index == rsp.frame_length && rsp.data_byte == 8'd0)
      else $error("malformed frame-end word");

   // no result straight out of reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp.valid)
      else $error("result valid right after reset");

endmodule

bind sync_length_crc16_deframer sld_checker u_sld_checker (
   .clock (clock),
   .reset (reset),
   .rsp   (rsp)
);
